// ----- hw/rtl/bilinear_pixel_interpolator_unit_assert.svh -----
// assertion macros used by the interpolator unit
`ifndef BILINEAR_PIXEL_INTERPOLATOR_UNIT_ASSERT_SVH
`define BILINEAR_PIXEL_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check that holds outside reset
`define BPI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bpi assertion failed");
// check that also holds during reset
`define BPI_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bpi reset assertion failed");
`else
`define BPI_ASSERT(lbl, prop)
`define BPI_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- hw/rtl/bpi_pkg.sv -----
// shared constants and types of the bilinear pixel interpolator
package bpi_pkg;
    localparam int FRAC_BITS_DEF = 8;
    localparam logic [7:0] CHAN_MAX = 8'hFF;
    localparam int NUM_STAGES = 9;
    localparam int DIV_STAGES = 4;

    // how the result of one request is formed
    typedef enum logic [1:0] {
        SEL_COPY,
        SEL_PLAIN,
        SEL_PREMUL
    } t_sel;
endpackage

// ----- hw/rtl/bpi_if.sv -----
// request, result and configuration channels
interface bpi_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frac_x;
    logic [7:0]  frac_y;
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;
    modport source (output valid, frac_x, frac_y, pixel_top_left, pixel_top_right,
                    pixel_bottom_left, pixel_bottom_right, input ready);
    modport sink (input valid, frac_x, frac_y, pixel_top_left, pixel_top_right,
                  pixel_bottom_left, pixel_bottom_right, output ready);
endinterface

interface bpi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
    modport sink (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface bpi_cfg_if;
    logic valid;
    logic ready;
    logic alpha_enable;
    modport source (output valid, alpha_enable, input ready);
    modport sink (input valid, alpha_enable, output ready);
endinterface

// ----- hw/rtl/bpi_lane.sv -----
// one channel lane: optional premultiply, weighting and weighted sum
module bpi_lane #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic [2:0]             i_en,
    input  logic [7:0]             i_chan  [4],
    input  logic [7:0]             i_alpha [4],
    input  logic                   i_premul,
    input  logic [2*FRAC_BITS:0]   i_w     [4],
    output logic [15:0]            o_m
);
    localparam int WW = 2 * FRAC_BITS + 1;
    localparam int PW = 16 + WW;
    localparam int SW = PW + 2;

    logic [15:0]   r_v [4];
    logic [PW-1:0] r_p [4];
    logic [15:0]   r_m;
    logic [SW-1:0] n_sum;

    // premultiply by alpha where needed
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_en[0]) begin
                r_v[k] <= i_premul ? 16'(i_alpha[k]) * 16'(i_chan[k]) : {8'h00, i_chan[k]};
            end
        end
    end

    // one product per corner
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_en[1]) begin
                r_p[k] <= PW'(r_v[k]) * PW'(i_w[k]);
            end
        end
    end

    // merge the corners and drop the fraction bits
    always_comb begin
        n_sum = SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]) + SW'(r_p[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_m <= n_sum[2*FRAC_BITS +: 16];
        end
    end

    assign o_m = r_m;
endmodule

// ----- hw/rtl/bpi_div.sv -----
// pipelined 8-bit quotient divider with saturation, two bits per stage
module bpi_div (
    input  logic                          i_clk,
    input  logic [bpi_pkg::DIV_STAGES-1:0] i_en,
    input  logic [15:0]                   i_m,
    input  logic [7:0]                    i_d,
    output logic [7:0]                    o_q
);
    localparam int NS = bpi_pkg::DIV_STAGES;

    logic [15:0] r_rem [NS];
    logic [7:0]  r_q   [NS];
    logic [7:0]  r_d   [NS];
    logic        r_sat [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [15:0] n_rem;
        logic [7:0]  n_q;
        logic [7:0]  c_d;
        logic        n_sat;

        // two restoring steps
        always_comb begin
            logic [15:0] rem;
            logic [15:0] dsh;
            logic [7:0]  q;
            if (j == 0) begin
                rem   = i_m;
                q     = 8'h00;
                c_d   = i_d;
                n_sat = (i_m >= {i_d, 8'h00});
            end else begin
                rem   = r_rem[j-1];
                q     = r_q[j-1];
                c_d   = r_d[j-1];
                n_sat = r_sat[j-1];
            end
            for (int t = 0; t < 2; t++) begin
                dsh = {8'h00, c_d} << (7 - 2 * j - t);
                if (rem >= dsh) begin
                    rem = rem - dsh;
                    q[7 - 2 * j - t] = 1'b1;
                end
            end
            n_rem = rem;
            n_q   = q;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_d[j]   <= c_d;
                r_sat[j] <= n_sat;
            end
        end
    end

    assign o_q = r_sat[NS-1] ? bpi_pkg::CHAN_MAX : r_q[NS-1];
endmodule

// ----- hw/rtl/bilinear_pixel_interpolator_unit.sv -----
// Bilinear BGRA pixel interpolator: one request per clock while the output is not stalled,
// through nine pipeline registers. Stages: input and case decision, weights and premultiply,
// corner products, weighted sum, four divider stages
// (two quotient bits each, for the division of premultiplied colour by interpolated
// alpha), and the result register that merges the lanes. Each stage moves on when it is
// empty or the next one moves, so the pipeline keeps taking requests while a result
// waits until all nine stages hold one.
`include "bilinear_pixel_interpolator_unit_assert.svh"
module bilinear_pixel_interpolator_unit #(
    parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpi_cfg_if.sink   i_cfg,
    bpi_in_if.sink    i_pix,
    bpi_out_if.source o_pix
);
    localparam int NS = bpi_pkg::NUM_STAGES;
    localparam int FW = FRAC_BITS;
    localparam int WW = 2 * FRAC_BITS + 1;
    localparam logic [FW-1:0] FMAX = '1;
    localparam logic [FW:0] SVAL = (FW + 1)'(1) << FW;

    logic            r_alpha_en;
    logic [NS-1:0]   r_v;
    logic [NS-1:0]   en;
    bpi_pkg::t_sel   r_sel  [NS-1];
    logic [31:0]     r_base [NS-1];
    logic [FW-1:0]   r_fx, r_fy;
    logic [31:0]     r_px   [4];
    logic [WW-1:0]   r_w    [4];
    logic [7:0]      r_ao   [4:7];
    logic [7:0]      r_blue, r_green, r_red, r_alpha;

    logic [FW-1:0]   n_fx, n_fy;
    bpi_pkg::t_sel   n_sel;
    logic [31:0]     n_base;
    logic [FW:0]     sx, sy;
    logic [15:0]     m    [4];
    logic [7:0]      q    [3];
    logic [7:0]      ch   [4][4];
    logic [7:0]      alp  [4];
    logic [7:0]      div_d;

    // configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en <= 1'b0;
        end else if (i_cfg.valid) begin
            r_alpha_en <= i_cfg.alpha_enable;
        end
    end

    // stage enables, from the output back
    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_pix.ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end
    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // clamp fractions and decide the case
    always_comb begin
        logic [31:0] p0, p1, p2, p3;
        logic        all_eq, rgb_eq, frac0, opaque;
        p0 = i_pix.pixel_top_left;
        p1 = i_pix.pixel_top_right;
        p2 = i_pix.pixel_bottom_left;
        p3 = i_pix.pixel_bottom_right;
        n_fx = (FRAC_BITS < 8 && 32'(i_pix.frac_x) > 32'(FMAX)) ? FMAX : FW'(i_pix.frac_x);
        n_fy = (FRAC_BITS < 8 && 32'(i_pix.frac_y) > 32'(FMAX)) ? FMAX : FW'(i_pix.frac_y);
        all_eq = (p0 == p1) && (p0 == p2) && (p0 == p3);
        rgb_eq = (p0[23:0] == p1[23:0]) && (p0[23:0] == p2[23:0]) && (p0[23:0] == p3[23:0]);
        frac0  = (n_fx == '0) && (n_fy == '0);
        opaque = ((p0[31:24] & p1[31:24] & p2[31:24] & p3[31:24]) == bpi_pkg::CHAN_MAX);
        if ((r_alpha_en && all_eq) || (!r_alpha_en && rgb_eq) || frac0) begin
            n_sel = bpi_pkg::SEL_COPY;
        end else if (!r_alpha_en || opaque) begin
            n_sel = bpi_pkg::SEL_PLAIN;
        end else begin
            n_sel = bpi_pkg::SEL_PREMUL;
        end
        n_base = {r_alpha_en ? p0[31:24] : bpi_pkg::CHAN_MAX, p0[23:0]};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_fx      <= n_fx;
            r_fy      <= n_fy;
            r_px[0]   <= i_pix.pixel_top_left;
            r_px[1]   <= i_pix.pixel_top_right;
            r_px[2]   <= i_pix.pixel_bottom_left;
            r_px[3]   <= i_pix.pixel_bottom_right;
            r_sel[0]  <= n_sel;
            r_base[0] <= n_base;
        end
        for (int i = 1; i < NS - 1; i++) begin
            if (en[i]) begin
                r_sel[i]  <= r_sel[i-1];
                r_base[i] <= r_base[i-1];
            end
        end
    end

    // corner weights
    assign sx = SVAL - {1'b0, r_fx};
    assign sy = SVAL - {1'b0, r_fy};
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_w[0] <= WW'(sx) * WW'(sy);
            r_w[1] <= WW'(r_fx) * WW'(sy);
            r_w[2] <= WW'(sx) * WW'(r_fy);
            r_w[3] <= WW'(r_fx) * WW'(r_fy);
        end
    end

    // channel slices: lane k, corner c
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 4; c++) begin
                ch[k][c] = r_px[c][8*k +: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            alp[c] = r_px[c][31:24];
        end
    end

    // colour lanes and the alpha lane
    for (genvar k = 0; k < 4; k++) begin : g_lane
        bpi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_en     (en[3:1]),
            .i_chan   (ch[k]),
            .i_alpha  (alp),
            .i_premul ((k < 3) && (r_sel[0] == bpi_pkg::SEL_PREMUL)),
            .i_w      (r_w),
            .o_m      (m[k])
        );
    end

    // divide by alpha only on the premultiplied path, else by one
    assign div_d = (r_sel[3] == bpi_pkg::SEL_PREMUL) ? m[3][7:0] : 8'd1;
    for (genvar k = 0; k < 3; k++) begin : g_div
        bpi_div u_div (
            .i_clk (i_clk),
            .i_en  (en[7:4]),
            .i_m   (m[k]),
            .i_d   (div_d),
            .o_q   (q[k])
        );
    end

    // interpolated alpha travels beside the divider
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_ao[4] <= m[3][7:0];
        end
        for (int i = 5; i <= 7; i++) begin
            if (en[i]) begin
                r_ao[i] <= r_ao[i-1];
            end
        end
    end

    // merge the lanes into the result register
    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            case (r_sel[7])
                bpi_pkg::SEL_COPY: begin
                    r_blue  <= r_base[7][7:0];
                    r_green <= r_base[7][15:8];
                    r_red   <= r_base[7][23:16];
                    r_alpha <= r_base[7][31:24];
                end
                bpi_pkg::SEL_PLAIN: begin
                    r_blue  <= q[0];
                    r_green <= q[1];
                    r_red   <= q[2];
                    r_alpha <= bpi_pkg::CHAN_MAX;
                end
                bpi_pkg::SEL_PREMUL: begin
                    r_blue  <= (r_ao[7] == 8'h00) ? bpi_pkg::CHAN_MAX : q[0];
                    r_green <= (r_ao[7] == 8'h00) ? bpi_pkg::CHAN_MAX : q[1];
                    r_red   <= (r_ao[7] == 8'h00) ? bpi_pkg::CHAN_MAX : q[2];
                    r_alpha <= r_ao[7];
                end
                default: begin
                    r_blue  <= bpi_pkg::CHAN_MAX;
                    r_green <= bpi_pkg::CHAN_MAX;
                    r_red   <= bpi_pkg::CHAN_MAX;
                    r_alpha <= bpi_pkg::CHAN_MAX;
                end
            endcase
        end
    end

    assign o_pix.valid     = r_v[NS-1];
    assign o_pix.out_blue  = r_blue;
    assign o_pix.out_green = r_green;
    assign o_pix.out_red   = r_red;
    assign o_pix.out_alpha = r_alpha;

    // checks
    `BPI_ASSERT(a_ready_when_drained, !r_v[NS-1] |-> i_pix.ready)
    `BPI_ASSERT(a_held_result_blocks_out, (r_v[NS-1] && !o_pix.ready) |=> r_v[NS-1])
    `BPI_ASSERT_RST(a_reset_empties, !i_rst_n |=> (r_v == '0))
endmodule
